// ----- rtl/thwb_pkg.sv -----
// Shared types and codes for the two-wire handshaked byte transfer core.
package thwb_pkg;

	// Function codes carried in the input tuser
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// Transfer mode codes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// Handshake phase codes within one bit
	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;
	localparam logic [1:0] PH_3 = 2'd3;

	// Bit position of the shift register that leaves or enters first
	localparam int MSB_POS = 7;

	// One input item
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] byte_in;
		logic       clk_line;
		logic       data_line;
	} item_t;

	// One result item
	typedef struct packed {
		logic       clk_assert;
		logic       data_assert;
		logic       busy_res;
		logic       done_res;
		logic [7:0] byte_out;
	} result_t;

endpackage

// ----- rtl/thwb_in_stage.sv -----
// Input register stage of the transfer core: holds one accepted item.
module thwb_in_stage
	import thwb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  valid_s1,
	input  logic  adv,
	output item_t item_s1
);

	logic valid_q;

	assign in_ready = !valid_q || adv;
	assign valid_s1 = valid_q;

	// Track occupancy of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Capture the item on each transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- rtl/thwb_engine.sv -----
// Bit handshake sequencer: transfer state and its next-state logic.
module thwb_engine
	import thwb_pkg::*;
#(
	parameter int BITS_PER_BYTE = 8
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  item_t   item,
	output result_t res
);

	localparam int CW = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;
	localparam logic [CW-1:0] LAST_CNT = CW'(BITS_PER_BYTE - 1);

	logic [1:0]    mode_q, mode_d;
	logic [1:0]    phase_q, phase_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [7:0]    shift_q, shift_d;
	logic          sampled_q, sampled_d;
	logic          clk_drv_q, clk_drv_d;
	logic          data_drv_q, data_drv_d;
	logic          done;
	logic [7:0]    rx_byte;
	logic          last_bit;
	logic [7:0]    shl;

	assign last_bit = (cnt_q == LAST_CNT);
	assign shl      = {shift_q[6:0], 1'b0};

	// Advance the handshake for one item
	always_comb begin
		mode_d     = mode_q;
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		shift_d    = shift_q;
		sampled_d  = sampled_q;
		clk_drv_d  = clk_drv_q;
		data_drv_d = data_drv_q;
		done       = 1'b0;
		rx_byte    = 8'd0;
		if (item.func == FUNC_WRITE && mode_q == MODE_IDLE) begin
			mode_d     = MODE_WRITE;
			shift_d    = item.byte_in;
			cnt_d      = '0;
			data_drv_d = item.byte_in[MSB_POS];
			clk_drv_d  = 1'b0;
			phase_d    = PH_1;
		end else if (item.func == FUNC_READ && mode_q == MODE_IDLE) begin
			mode_d  = MODE_READ;
			shift_d = 8'd0;
			cnt_d   = '0;
			phase_d = PH_0;
		end else if (item.func == FUNC_TICK && mode_q == MODE_WRITE) begin
			case (phase_q)
				PH_1: begin
					if (item.clk_line) begin
						data_drv_d = !shift_q[MSB_POS];
						phase_d    = PH_2;
					end
				end
				PH_2: begin
					if (!item.clk_line) begin
						data_drv_d = 1'b0;
						clk_drv_d  = 1'b1;
						phase_d    = PH_3;
					end
				end
				default: begin
					if (item.data_line) begin
						shift_d = shl;
						if (last_bit) begin
							mode_d  = MODE_IDLE;
							phase_d = PH_0;
							cnt_d   = '0;
							done    = 1'b1;
						end else begin
							cnt_d      = cnt_q + 1'b1;
							data_drv_d = shl[MSB_POS];
							clk_drv_d  = 1'b0;
							phase_d    = PH_1;
						end
					end
				end
			endcase
		end else if (item.func == FUNC_TICK && mode_q == MODE_READ) begin
			case (phase_q)
				PH_0: begin
					if (!item.data_line) begin
						clk_drv_d = 1'b0;
						phase_d   = PH_1;
					end
				end
				PH_1: begin
					sampled_d  = item.clk_line;
					shift_d    = {item.clk_line, shift_q[7:1]};
					data_drv_d = 1'b1;
					phase_d    = PH_2;
				end
				PH_2: begin
					if (item.clk_line != sampled_q) begin
						data_drv_d = 1'b0;
						phase_d    = PH_3;
					end
				end
				default: begin
					if (item.data_line) begin
						clk_drv_d = 1'b1;
						if (last_bit) begin
							mode_d  = MODE_IDLE;
							phase_d = PH_0;
							cnt_d   = '0;
							done    = 1'b1;
							rx_byte = shift_q;
						end else begin
							cnt_d   = cnt_q + 1'b1;
							phase_d = PH_0;
						end
					end
				end
			endcase
		end
	end

	// Form the result from the next state
	always_comb begin
		res.clk_assert  = clk_drv_d;
		res.data_assert = data_drv_d;
		res.busy_res    = (mode_d != MODE_IDLE);
		res.done_res    = done;
		res.byte_out    = rx_byte;
	end

	// Hold the transfer state; update only when an item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			phase_q    <= PH_0;
			cnt_q      <= '0;
			shift_q    <= 8'd0;
			sampled_q  <= 1'b0;
			clk_drv_q  <= 1'b1;
			data_drv_q <= 1'b0;
		end else if (adv) begin
			mode_q     <= mode_d;
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			shift_q    <= shift_d;
			sampled_q  <= sampled_d;
			clk_drv_q  <= clk_drv_d;
			data_drv_q <= data_drv_d;
		end
	end

endmodule

// ----- rtl/two_wire_handshake_byte_transfer_core.sv -----
// Top level of the two-wire handshaked byte transfer core.
// Each item passes the input register, then the result register, before its result leaves;
// one item per cycle sustained while m_tready does not stall the result register.
// The sequencer state updates in the single logic step between the two registers.
// Reset (arst_n low) empties both registers, returns to idle with clock
// asserted and data released.
module two_wire_handshake_byte_transfer_core
	import thwb_pkg::*;
#(
	parameter int BITS_PER_BYTE = 8
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // byte_in[7:0], clk_line[8], data_line[9], zero[15:10]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // clk_assert[0], data_assert[1], busy_res[2],
	                              // done_res[3], byte_out[11:4], zero[15:12]
);

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    adv;
	result_t res;
	result_t res_q;
	logic    out_valid_q;

	// Unpack the incoming transfer
	always_comb begin
		in_item.func      = s_tuser;
		in_item.byte_in   = s_tdata[7:0];
		in_item.clk_line  = s_tdata[8];
		in_item.data_line = s_tdata[9];
	end

	assign adv = valid_s1 && (!out_valid_q || m_tready);

	thwb_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.adv      (adv),
		.item_s1  (item_s1)
	);

	thwb_engine #(
		.BITS_PER_BYTE (BITS_PER_BYTE)
	) u_eng (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.res    (res)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, res_q.byte_out, res_q.done_res, res_q.busy_res,
		res_q.data_assert, res_q.clk_assert};

endmodule
